FILE: hdl/tpi_pkg.sv
// Shared types, constants and arithmetic helpers for the trajectory point interpolator.
`default_nettype none

package tpi_pkg;

    // Default number of points that bounds the span setting.
    localparam int MAX_POINTS_DEF = 1024;

    // Fixed-point and field widths.
    localparam int POS_W  = 32;
    localparam int DIFF_W = 33;
    localparam int IDX_W  = 10;
    localparam int Q_W    = 17;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 10;
    localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

    // Interpolation modes.
    localparam logic [1:0] MODE_LINEAR  = 2'd0;
    localparam logic [1:0] MODE_CUBIC   = 2'd1;
    localparam logic [1:0] MODE_MINJERK = 2'd2;

    // Configuration register indexes.
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_SPAN = 1'b1;

    // Word carried through the divider stages.
    typedef struct packed {
        logic signed [POS_W-1:0]  x0;
        logic signed [DIFF_W-1:0] d;
        logic [1:0]               mode;
        logic [IDX_W-1:0]         sp;
        logic [IDX_W-1:0]         rem;
        logic [Q_W-1:0]           num;
    } t_div;

    // Word carried through the power stages.
    typedef struct packed {
        logic signed [POS_W-1:0]  x0;
        logic signed [DIFF_W-1:0] d;
        logic [1:0]               mode;
        logic [Q_W-1:0]           tau;
        logic [Q_W-1:0]           t2;
        logic [Q_W-1:0]           t3;
        logic [Q_W-1:0]           t4;
        logic [Q_W-1:0]           t5;
    } t_pow;

    // One restoring division step: one quotient bit shifts in as one dividend bit shifts out.
    function automatic t_div div_step(input t_div a);
        t_div             r;
        logic [IDX_W:0]   tr;
        r  = a;
        tr = {a.rem, a.num[Q_W-1]};
        if (tr >= {1'b0, a.sp}) begin
            r.rem = IDX_W'(tr - {1'b0, a.sp});
            r.num = {a.num[Q_W-2:0], 1'b1};
        end else begin
            r.rem = tr[IDX_W-1:0];
            r.num = {a.num[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Rounded Q1.16 product of two values no larger than one.
    function automatic logic [Q_W-1:0] rnd_q16(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [2*Q_W-1:0] p;
        logic [2*Q_W:0]   w;
        p = a * b;
        w = {1'b0, p} + (2*Q_W+1)'(32768);
        return w[FRAC_W+Q_W-1:FRAC_W];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/trajectory_point_interpolator_core.sv
// Top level of the trajectory point interpolator: divider, power chain and blend pipeline.
//
//  channel   direction  signals                          word
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata  start, end, point index
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata  interpolated position
//  cfg       in         i_cfg_we/i_cfg_idx/i_cfg_data    mode, span
//
// A word passes 25 register stages between acceptance and the output: one capture stage,
// seventeen stages of the one-bit-per-stage tau divider, four multiplier stages for the
// powers of tau, then blend, difference product and final add.
// One word enters per cycle unless an output stall has filled every stage.
// Reset is synchronous; it clears the valid bits and sets mode to min-jerk and span to 2.
// A stall at the output only holds stages that are full; empty stages keep filling.
`default_nettype none

module trajectory_point_interpolator_core
    import tpi_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // Bits from 0: start_position[31:0], end_position[31:0], point_index[9:0], zero pad.
    input  wire logic [79:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // Bits from 0: position[31:0].
    output logic [31:0]      o_m_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    localparam int DIV_ST = Q_W;
    localparam int S_PW   = DIV_ST + 1;
    localparam int S_BL   = S_PW + 4;
    localparam int S_PR   = S_BL + 1;
    localparam int S_OUT  = S_PR + 1;
    localparam int NST    = S_OUT + 1;

    logic [1:0]       r_mode;
    logic [IDX_W-1:0] r_span;
    logic [NST-1:0]   r_vld;
    logic [NST:0]     en;

    t_div r_dv [DIV_ST+1];
    t_pow r_pw [4];
    t_pow n_pw [4];

    logic signed [POS_W-1:0]  r_x0_bl, r_x0_pr;
    logic signed [DIFF_W-1:0] r_d_bl;
    logic [Q_W-1:0]           r_s_bl;
    logic signed [DIFF_W+Q_W:0] r_prod;
    logic signed [POS_W-1:0]  r_pos;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_MINJERK;
            r_span <= IDX_W'(2);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE: r_mode <= i_cfg_data[1:0];
                REG_SPAN: r_span <= i_cfg_data;
                default:  r_mode <= r_mode;
            endcase
        end
    end

    // Each stage moves when it is empty or the stage after it moves.
    always_comb begin
        en[NST] = i_m_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];
    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = r_pos;

    // Effective span, saturated index and divider setup.
    logic [IDX_W-1:0]       sp_eff, idx_sat;
    logic [IDX_W+FRAC_W-1:0] numer;
    t_div                   cap;
    always_comb begin
        sp_eff = (r_span == '0) ? IDX_W'(1) : r_span;
        if (32'(sp_eff) >= MAX_POINTS) begin
            sp_eff = IDX_W'(MAX_POINTS - 1);
        end
        idx_sat = (i_s_tdata[73:64] > sp_eff) ? sp_eff : i_s_tdata[73:64];
        numer   = {idx_sat, {FRAC_W{1'b0}}} + (IDX_W+FRAC_W)'(sp_eff >> 1);
        cap.x0   = $signed(i_s_tdata[31:0]);
        cap.d    = DIFF_W'($signed(i_s_tdata[63:32])) - DIFF_W'($signed(i_s_tdata[31:0]));
        cap.mode = r_mode;
        cap.sp   = sp_eff;
        cap.rem  = IDX_W'(numer[IDX_W+FRAC_W-1:Q_W]);
        cap.num  = numer[Q_W-1:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Capture and divider stages.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dv[0] <= cap;
        end
        for (int k = 1; k <= DIV_ST; k++) begin
            if (en[k]) begin
                r_dv[k] <= div_step(r_dv[k-1]);
            end
        end
    end

    // Power stages: one rounded multiply each.
    logic [Q_W-1:0] tau_c;
    assign tau_c = (r_dv[DIV_ST].num > ONE_Q16) ? ONE_Q16 : r_dv[DIV_ST].num;

    always_comb begin
        n_pw[0].x0   = r_dv[DIV_ST].x0;
        n_pw[0].d    = r_dv[DIV_ST].d;
        n_pw[0].mode = r_dv[DIV_ST].mode;
        n_pw[0].tau  = tau_c;
        n_pw[0].t2   = rnd_q16(tau_c, tau_c);
        n_pw[0].t3   = '0;
        n_pw[0].t4   = '0;
        n_pw[0].t5   = '0;
        n_pw[1]      = r_pw[0];
        n_pw[1].t3   = rnd_q16(r_pw[0].t2, r_pw[0].tau);
        n_pw[2]      = r_pw[1];
        n_pw[2].t4   = rnd_q16(r_pw[1].t3, r_pw[1].tau);
        n_pw[3]      = r_pw[2];
        n_pw[3].t5   = rnd_q16(r_pw[2].t4, r_pw[2].tau);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (en[S_PW+k]) begin
                r_pw[k] <= n_pw[k];
            end
        end
    end

    // Blend polynomial with clamp to [0, 1].
    logic signed [23:0] blend;
    logic [Q_W-1:0]     s_c;
    always_comb begin
        case (r_pw[3].mode)
            MODE_LINEAR: blend = 24'($signed({1'b0, r_pw[3].tau}));
            MODE_CUBIC:  blend = 24'sd3 * $signed({7'd0, r_pw[3].t2})
                               - 24'sd2 * $signed({7'd0, r_pw[3].t3});
            default:     blend = 24'sd10 * $signed({7'd0, r_pw[3].t3})
                               - 24'sd15 * $signed({7'd0, r_pw[3].t4})
                               + 24'sd6 * $signed({7'd0, r_pw[3].t5});
        endcase
        if (blend < 0) begin
            s_c = '0;
        end else if (blend > $signed({7'd0, ONE_Q16})) begin
            s_c = ONE_Q16;
        end else begin
            s_c = blend[Q_W-1:0];
        end
    end

    // Blend, difference product and final rounded add.
    logic signed [DIFF_W+Q_W:0] prod_rnd;
    assign prod_rnd = r_prod + (DIFF_W+Q_W+1)'(32768);

    always_ff @(posedge i_clk) begin
        if (en[S_BL]) begin
            r_x0_bl <= r_pw[3].x0;
            r_d_bl  <= r_pw[3].d;
            r_s_bl  <= s_c;
        end
        if (en[S_PR]) begin
            r_x0_pr <= r_x0_bl;
            r_prod  <= r_d_bl * $signed({1'b0, r_s_bl});
        end
        if (en[S_OUT]) begin
            r_pos <= r_x0_pr + POS_W'(prod_rnd >>> FRAC_W);
        end
    end

    // Checks on the datapath and the stall logic.
    a_tau_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_PW] |-> (r_pw[0].tau <= ONE_Q16))
        else $error("tau above one after divider");

    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[S_BL] |-> (r_s_bl <= ONE_Q16))
        else $error("blend out of range");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_vld))
        else $error("input stalled with an empty stage");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("output word lost under stall");

endmodule

`default_nettype wire

FILE: verif/trajectory_point_interpolator_core_tb.sv
// Self-checking testbench for the trajectory point interpolator core.
`default_nettype none

module trajectory_point_interpolator_core_tb;
    import tpi_pkg::*;

    // Input word fields as they are packed into the stream data.
    typedef struct {
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic [9:0]         idx;
    } t_point;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [79:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = REG_MODE;
    logic [CFG_W-1:0] i_cfg_data = '0;

    logic [1:0]  mode_shadow;
    logic [9:0]  span_shadow;
    t_point      point_q[$];
    logic [31:0] position_q[$];
    int          err_count = 0;
    bit          calm = 1'b0;
    bit          hold_long = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;

    trajectory_point_interpolator_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Rounded Q16 product of two non-negative values.
    function automatic logic [63:0] q16_mul(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    // Expected position for one point under the current mode and span.
    function automatic logic [31:0] interp_position(input t_point p);
        logic [63:0]        sp, ix, tau, t2, t3, t4, t5;
        logic signed [63:0] s, d, prod;
        sp = span_shadow;
        if (sp == 0) sp = 1;
        if (sp >= 1024) sp = 1023;
        ix = p.idx;
        if (ix > sp) ix = sp;
        tau = (ix * 65536 + sp / 2) / sp;
        if (tau > 65536) tau = 65536;
        t2 = q16_mul(tau, tau);
        t3 = q16_mul(t2, tau);
        t4 = q16_mul(t3, tau);
        t5 = q16_mul(t4, tau);
        if (mode_shadow == MODE_LINEAR) s = $signed(tau);
        else if (mode_shadow == MODE_CUBIC) s = 3 * $signed(t2) - 2 * $signed(t3);
        else s = 10 * $signed(t3) - 15 * $signed(t4) + 6 * $signed(t5);
        if (s < 0) s = 0;
        if (s > 65536) s = 65536;
        d = 64'(p.x1) - 64'(p.x0);
        prod = d * s + 64'sd32768;
        return 32'(64'(p.x0) + (prod >>> 16));
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // Driver: offers queued points, with random gaps.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                position_q.push_back(interp_position(point_q.pop_front()));
            end
            if (!(i_s_tvalid && !o_s_tready)) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    src_gap <= $urandom_range(0, 17);
                    i_s_tvalid <= 1'b0;
                end else if (point_q.size() > (i_s_tvalid && o_s_tready ? 0 : 0)
                             && point_q.size() != 0) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {6'd0, point_q[0].idx, point_q[0].x1, point_q[0].x0};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each delivered position against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (position_q.size() == 0)
                    report_mismatch("position word with nothing expected");
                else if (o_m_tdata !== position_q[0]) begin
                    report_mismatch($sformatf("position got %h want %h",
                                              o_m_tdata, position_q[0]));
                    void'(position_q.pop_front());
                end else
                    void'(position_q.pop_front());
            end
            if (hold_long) begin
                i_m_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_gap <= $urandom_range(0, 17);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    task automatic add_point(input logic [31:0] a, input logic [31:0] b, input logic [9:0] k);
        t_point p;
        p.x0 = a;
        p.x1 = b;
        p.idx = k;
        point_q.push_back(p);
    endtask

    // Waits until every queued point has been accepted and every result checked.
    task automatic drain();
        while (point_q.size() != 0 || i_s_tvalid || position_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MODE) mode_shadow = val[1:0];
        else span_shadow = val;
    endtask

    task automatic random_points(input int n, input int sp);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: add_point($urandom, $urandom, 10'($urandom));
                1: add_point($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000,
                             $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000,
                             10'($urandom_range(0, sp + 1)));
                default: add_point($urandom, $urandom, 10'($urandom_range(0, sp)));
            endcase
        end
    endtask

    // Stimulus and end of run.
    initial begin
        int modes[4] = '{MODE_LINEAR, MODE_CUBIC, MODE_MINJERK, 3};
        int spans[6] = '{1, 1023, 0, 7, 100, 3};
        mode_shadow = MODE_MINJERK;
        span_shadow = 10'd2;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, field extremes, index beyond span.
        add_point(32'h80000000, 32'h7fffffff, 10'd1);
        add_point(32'h7fffffff, 32'h80000000, 10'd1);
        add_point(32'h0, 32'h00010000, 10'd0);
        add_point(32'hffffffff, 32'h0, 10'd2);
        add_point(32'h12345678, 32'hedcba987, 10'd1023);
        add_point(32'h0, 32'h0, 10'd3);
        drain();

        // Each mode against each span, the extremes among them.
        foreach (spans[j]) begin
            write_reg(REG_SPAN, CFG_W'(spans[j]));
            foreach (modes[m]) begin
                write_reg(REG_MODE, CFG_W'(modes[m]));
                calm = (j == 5);
                random_points(16, spans[j] < 2 ? 2 : spans[j]);
                if (j == 2 && m == 0) begin
                    // Long output stall so the pipeline backs up.
                    hold_long = 1'b1;
                    random_points(60, 2);
                    repeat (200) @(posedge i_clk);
                    hold_long = 1'b0;
                end
                drain();
            end
        end

        if (err_count == 0)
            $display("trajectory_point_interpolator_core_tb OK");
        else
            $display("trajectory_point_interpolator_core_tb NOT OK");
        $finish;
    end

    initial begin
        #2000000;
        $display("trajectory_point_interpolator_core_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

FILE: trajectory_point_interpolator_core.f
hdl/tpi_pkg.sv
hdl/trajectory_point_interpolator_core.sv
verif/trajectory_point_interpolator_core_tb.sv
